// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CHK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define CHK_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/pcaw_pkg.sv =====
// types, constants and helper functions of the whitened projection block
`default_nettype none

package pcaw_pkg;

    // store sizes
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 256;

    localparam int ROW_AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int BASIS_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int BASIS_AW    = $clog2(BASIS_DEPTH);
    localparam int NR_W        = $clog2(MAX_ROWS + 1);
    localparam int NC_W        = $clog2(MAX_COLS + 1);

    // arithmetic widths
    localparam int VAL_W     = 16;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + VAL_W;
    localparam int ACC_W     = PROD_W + COL_AW;
    localparam int ACC_SHIFT = 15;
    localparam int TQ_W      = ACC_W - ACC_SHIFT;
    localparam int SP_W      = TQ_W + VAL_W;
    localparam int SC_SHIFT  = 8;
    localparam int SH_W      = SP_W - SC_SHIFT;
    localparam int RES_W     = 32;

    // input actions
    localparam logic [1:0] ACT_BASIS  = 2'd0;
    localparam logic [1:0] ACT_MEAN   = 2'd1;
    localparam logic [1:0] ACT_SCALE  = 2'd2;
    localparam logic [1:0] ACT_SAMPLE = 2'd3;

    // configuration registers
    localparam int         CFG_IDX_W     = 1;
    localparam int         CFG_DW        = 9;
    localparam logic [0:0] CFG_ROWS_USED = 1'd0;
    localparam logic [0:0] CFG_COLS_USED = 1'd1;
    localparam logic [5:0] ROWS_USED_RST = 6'd32;
    localparam logic [8:0] COLS_USED_RST = 9'd256;

    typedef struct packed {
        logic [1:0]        action;
        logic [4:0]        row;
        logic [7:0]        column;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] projected_value;
        logic [4:0]         row_index;
        logic               last_of_vector;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              wr_basis;
        logic              wr_mean;
        logic              wr_scale;
        logic              wr_sample;
        logic              issue;
        logic              first;
        logic              last;
        logic              vec_last;
        logic [ROW_AW-1:0] row;
        logic [COL_AW-1:0] col;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic vec_done;
    } t_dp_stat;

    function automatic logic [NR_W-1:0] clamp_rows(input logic [5:0] v);
        if (v == 6'd0) begin
            return NR_W'(1);
        end else if (32'(v) > MAX_ROWS) begin
            return NR_W'(MAX_ROWS);
        end else begin
            return NR_W'(v);
        end
    endfunction

    function automatic logic [NC_W-1:0] clamp_cols(input logic [8:0] v);
        if (v == 9'd0) begin
            return NC_W'(1);
        end else if (32'(v) > MAX_COLS) begin
            return NC_W'(MAX_COLS);
        end else begin
            return NC_W'(v);
        end
    endfunction

    function automatic logic [BASIS_AW-1:0] basis_addr(input logic [ROW_AW-1:0] r,
                                                       input logic [COL_AW-1:0] c);
        return BASIS_AW'(BASIS_AW'(r) * BASIS_AW'(MAX_COLS) + BASIS_AW'(c));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcaw_dp.sv =====
// datapath: stores, multiply-accumulate pipeline, scaling and saturation
`default_nettype none

module pcaw_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcaw_pkg::t_dp_cmd         i_cmd,
    input  logic [pcaw_pkg::ROW_AW-1:0] i_wr_row,
    input  logic [pcaw_pkg::COL_AW-1:0] i_wr_col,
    input  logic signed [15:0]        i_wr_value,
    output pcaw_pkg::t_dp_stat        o_stat,
    output logic                      o_res_strobe,
    output pcaw_pkg::t_out_item       o_result
);
    import pcaw_pkg::*;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              vec_last;
        logic [ROW_AW-1:0] row;
    } t_tag;

    logic signed [VAL_W-1:0] basis_mem  [BASIS_DEPTH];
    logic signed [VAL_W-1:0] mean_mem   [MAX_COLS];
    logic signed [VAL_W-1:0] scale_mem  [MAX_ROWS];
    logic signed [VAL_W-1:0] sample_mem [MAX_COLS];

    logic signed [VAL_W-1:0]  r_basis_q, r_mean_q, r_scale_q, r_smp_q;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [VAL_W-1:0]  r_b2, r_sc2, r_sc3, r_sc4;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [TQ_W-1:0]   r_tq;
    logic signed [SP_W-1:0]   r_sp;
    t_tag                     r_t1, r_t2, r_t3, r_t4, r_t5;
    t_out_item                r_res;
    logic                     r_strobe;

    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [SH_W-1:0]   shifted;
    logic                     fits;
    logic signed [RES_W-1:0]  sat;

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_basis) begin
            basis_mem[basis_addr(i_wr_row, i_wr_col)] <= i_wr_value;
        end
        if (i_cmd.issue) begin
            r_basis_q <= basis_mem[basis_addr(i_cmd.row, i_cmd.col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mean) begin
            mean_mem[i_wr_col] <= i_wr_value;
        end
        if (i_cmd.issue) begin
            r_mean_q <= mean_mem[i_cmd.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_scale) begin
            scale_mem[i_wr_row] <= i_wr_value;
        end
        if (i_cmd.issue) begin
            r_scale_q <= scale_mem[i_cmd.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample) begin
            sample_mem[i_wr_col] <= i_wr_value;
        end
        if (i_cmd.issue) begin
            r_smp_q <= sample_mem[i_cmd.col];
        end
    end

    always_comb begin
        acc_sum = r_t3.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        shifted = SH_W'(r_sp >>> SC_SHIFT);
        fits    = (&shifted[SH_W-1:RES_W-1]) | ~(|shifted[SH_W-1:RES_W-1]);
        if (fits) begin
            sat = shifted[RES_W-1:0];
        end else if (shifted[SH_W-1]) begin
            sat = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(RES_W-1){1'b1}}};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_diff <= DIFF_W'(r_smp_q) - DIFF_W'(r_mean_q);
        r_b2   <= r_basis_q;
        r_sc2  <= r_scale_q;
        r_prod <= r_diff * r_b2;
        r_sc3  <= r_sc2;
        if (r_t3.valid) begin
            r_acc <= acc_sum;
        end
        if (r_t3.valid && r_t3.last) begin
            r_tq  <= TQ_W'(acc_sum >>> ACC_SHIFT);
            r_sc4 <= r_sc3;
        end
        if (r_t4.valid) begin
            r_sp <= r_tq * r_sc4;
        end
        if (r_t5.valid) begin
            r_res.projected_value <= sat;
            r_res.row_index       <= 5'(r_t5.row);
            r_res.last_of_vector  <= r_t5.vec_last;
        end
    end

    // tag stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1     <= '0;
            r_t2     <= '0;
            r_t3     <= '0;
            r_t4     <= '0;
            r_t5     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_t1.valid    <= i_cmd.issue;
            r_t1.first    <= i_cmd.first;
            r_t1.last     <= i_cmd.last;
            r_t1.vec_last <= i_cmd.vec_last;
            r_t1.row      <= i_cmd.row;
            r_t2          <= r_t1;
            r_t3          <= r_t2;
            r_t4.valid    <= r_t3.valid & r_t3.last;
            r_t4.first    <= r_t3.first;
            r_t4.last     <= r_t3.last;
            r_t4.vec_last <= r_t3.vec_last;
            r_t4.row      <= r_t3.row;
            r_t5          <= r_t4;
            r_strobe      <= r_t5.valid;
        end
    end

    assign o_stat.vec_done = r_strobe & r_res.last_of_vector;
    assign o_res_strobe    = r_strobe;
    assign o_result        = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/pcaw_ctrl.sv =====
// controller: configuration registers, load decode and row/column sequencer
`default_nettype none

module pcaw_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_action,
    input  logic [4:0]                    i_row,
    input  logic [7:0]                    i_column,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcaw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcaw_pkg::CFG_DW-1:0]    i_cfg_data,
    input  pcaw_pkg::t_dp_stat            i_stat,
    output pcaw_pkg::t_dp_cmd             o_cmd
);
    import pcaw_pkg::*;

    t_state            r_state, n_state;
    logic [NR_W-1:0]   r_nr;
    logic [NC_W-1:0]   r_nc;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [COL_AW-1:0] r_col, n_col;

    logic accept, row_ok, col_ok, final_smp, col_end, row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nr    <= clamp_rows(ROWS_USED_RST);
            r_nc    <= clamp_cols(COLS_USED_RST);
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROWS_USED: r_nr <= clamp_rows(i_cfg_data[5:0]);
                    CFG_COLS_USED: r_nc <= clamp_cols(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        accept    = i_start & (r_state == ST_IDLE);
        row_ok    = 32'(i_row) < MAX_ROWS;
        col_ok    = 32'(i_column) < MAX_COLS;
        final_smp = col_ok & ((32'(i_column) + 32'd1) == 32'(r_nc));
        col_end   = r_col == COL_AW'(r_nc - NC_W'(1));
        row_end   = r_row == ROW_AW'(r_nr - NR_W'(1));

        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        o_cmd   = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_BASIS:  o_cmd.wr_basis  = row_ok & col_ok;
                        ACT_MEAN:   o_cmd.wr_mean   = col_ok;
                        ACT_SCALE:  o_cmd.wr_scale  = row_ok;
                        ACT_SAMPLE: begin
                            o_cmd.wr_sample = col_ok;
                            if (final_smp) begin
                                n_state = ST_RUN;
                                n_row   = '0;
                                n_col   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.issue    = 1'b1;
                o_cmd.row      = r_row;
                o_cmd.col      = r_col;
                o_cmd.first    = r_col == '0;
                o_cmd.last     = col_end;
                o_cmd.vec_last = col_end & row_end;
                if (col_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_stat.vec_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/pca_whitened_projection.sv =====
// top level of the whitened projection block
`default_nettype none

// whitened pca projection. a beat on the input side is accepted when start
// is high and busy is low; it either loads one basis entry (q1.15), one mean
// entry, one row scale (q8.8) or one sample of the feature vector. loads and
// ordinary samples leave busy low. the sample at position cols_used-1
// completes the vector: busy then stays high while one multiply-accumulate
// unit walks the basis store one entry per cycle (its single read port sets
// the pace), and the rows_used results leave one by one on o_result, each
// marked by a single-cycle o_res_strobe, the last one flagged by
// last_of_vector. the receiver cannot stall:
// every strobed beat must be taken in that cycle.
// stores are not cleared by reset; entries must be written before use.
// configuration is taken at any cycle with i_cfg_valid (ready is always
// high) and must only be written while busy is low; rows_used and cols_used
// are clamped to the store sizes on write.

module pca_whitened_projection (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pcaw_pkg::t_in_item            i_item,
    output logic                          o_res_strobe,
    output pcaw_pkg::t_out_item           o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcaw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcaw_pkg::CFG_DW-1:0]    i_cfg_data
);
    import pcaw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: decodes load beats, walks rows and columns of the basis
    pcaw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_action    (i_item.action),
        .i_row       (i_item.row),
        .i_column    (i_item.column),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // stores plus mac, floor shift, scale multiply and saturation pipeline
    pcaw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_row     (ROW_AW'(i_item.row)),
        .i_wr_col     (COL_AW'(i_item.column)),
        .i_wr_value   (i_item.value),
        .o_stat       (stat),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pcaw_checker.sv =====
// port-level checker for the whitened projection block, with its bind
`default_nettype none

`include "assert_macros.svh"

module pcaw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_res_strobe,
    input pcaw_pkg::t_out_item o_result
);

    // final beat of a vector
    logic res_last;
    assign res_last = o_res_strobe && o_result.last_of_vector;

    // results only appear while a vector is in progress
    `CHK_NEVER(a_strobe_idle, o_res_strobe && !busy, "result beat while idle")

    // busy drops only right after the final beat of a vector
    `CHK_ASSERT(a_busy_end, $fell(busy) |-> $past(res_last), "busy dropped before final beat")

    // nothing follows the final beat directly
    `CHK_ASSERT(a_last_gap, res_last |=> !o_res_strobe, "beat after final beat")

    // busy only rises after a start
    `CHK_ASSERT(a_busy_cause, $rose(busy) |-> $past(start), "busy without start")

endmodule

bind pca_whitened_projection pcaw_checker u_pcaw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_result     (o_result)
);

`default_nettype wire
